// ===== rtl/core/alpha_bilateral_filter_core_assert.svh =====
// Assertion macros for the alpha bilateral filter core
`ifndef ALPHA_BILATERAL_FILTER_CORE_ASSERT_SVH
`define ALPHA_BILATERAL_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ABF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("abf assertion failed");
`define ABF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("abf reset assertion failed");
`else
`define ABF_ASSERT(lbl, prop)
`define ABF_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/core/abf_pkg.sv =====
package abf_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int PIX_W   = 8;
  localparam int CELL_W  = 9;
  localparam int FW_W    = 13;
  localparam int FH_W    = 16;
  localparam int QF_W    = 16;
  localparam int TOTAL_W = FW_W + FH_W;
  localparam int VW_W    = 11;
  localparam int KK_W    = 21;
  localparam int WGT_W   = 11;
  localparam int SUM_W   = 23;
  localparam int TSUM_W  = 15;
  localparam int NUM_W   = 24;
  localparam int ENABLE_THRESHOLD = 10;

  localparam logic [1:0] REG_FILTER_ON = 2'd0;
  localparam logic [1:0] REG_QUALITY   = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  localparam logic [1:0] VSEL_S5  = 2'd0;
  localparam logic [1:0] VSEL_S10 = 2'd1;
  localparam logic [1:0] VSEL_S20 = 2'd2;

  typedef struct packed {
    logic               filter_en;
    logic               rad1;
    logic [1:0]         vsel;
    logic [FW_W-1:0]    w;
    logic [FH_W-1:0]    h;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

  localparam logic [VW_W-1:0] VW_S5 [20] = '{
    11'd1024, 11'd1004, 11'd945, 11'd855, 11'd744, 11'd621, 11'd498, 11'd384,
    11'd285, 11'd203, 11'd139, 11'd91, 11'd57, 11'd35, 11'd20, 11'd11, 11'd6,
    11'd3, 11'd2, 11'd1};

  localparam logic [VW_W-1:0] VW_S10 [40] = '{
    11'd1024, 11'd1019, 11'd1004, 11'd979, 11'd945, 11'd904, 11'd855, 11'd801,
    11'd744, 11'd683, 11'd621, 11'd559, 11'd498, 11'd440, 11'd384, 11'd332,
    11'd285, 11'd241, 11'd203, 11'd168, 11'd139, 11'd113, 11'd91, 11'd73,
    11'd57, 11'd45, 11'd35, 11'd27, 11'd20, 11'd15, 11'd11, 11'd8, 11'd6,
    11'd4, 11'd3, 11'd2, 11'd2, 11'd1, 11'd1, 11'd1};

  localparam logic [VW_W-1:0] VW_S20 [79] = '{
    11'd1024, 11'd1023, 11'd1019, 11'd1013, 11'd1004, 11'd992, 11'd979, 11'd963,
    11'd945, 11'd925, 11'd904, 11'd880, 11'd855, 11'd829, 11'd801, 11'd773,
    11'd744, 11'd714, 11'd683, 11'd652, 11'd621, 11'd590, 11'd559, 11'd529,
    11'd498, 11'd469, 11'd440, 11'd412, 11'd384, 11'd358, 11'd332, 11'd308,
    11'd285, 11'd262, 11'd241, 11'd221, 11'd203, 11'd185, 11'd168, 11'd153,
    11'd139, 11'd125, 11'd113, 11'd102, 11'd91, 11'd81, 11'd73, 11'd65,
    11'd57, 11'd51, 11'd45, 11'd40, 11'd35, 11'd31, 11'd27, 11'd23, 11'd20,
    11'd18, 11'd15, 11'd13, 11'd11, 11'd10, 11'd8, 11'd7, 11'd6, 11'd5, 11'd4,
    11'd4, 11'd3, 11'd3, 11'd2, 11'd2, 11'd2, 11'd1, 11'd1, 11'd1, 11'd1,
    11'd1, 11'd1};

  function automatic logic [VW_W-1:0] vw_lookup(logic [1:0] vsel, logic [PIX_W-1:0] diff);
    logic [VW_W-1:0] v;
    v = '0;
    case (vsel)
      VSEL_S5:  if (diff < 8'd20) v = VW_S5[diff[4:0]];
      VSEL_S10: if (diff < 8'd40) v = VW_S10[diff[5:0]];
      default:  if (diff < 8'd79) v = VW_S20[diff[6:0]];
    endcase
    return v;
  endfunction

  function automatic logic [VW_W-1:0] gauss(logic rad1, logic [1:0] a);
    logic [VW_W-1:0] g;
    case (a)
      2'd0:    g = 11'd1024;
      2'd1:    g = rad1 ? 11'd621 : 11'd797;
      2'd2:    g = rad1 ? 11'd0 : 11'd377;
      default: g = 11'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/core/alpha_bilateral_filter_core.sv =====
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata: pixel_value; tuser: func, smooth_enable
// out_    | out | out_tvalid/tready  | tdata: pixel_out; tlast: frame_last
// cfg_    | in  | APB psel/penable   | four registers at 0x0, 0x4, 0x8, 0xC
// An early flush stays in S_IDLE; other items pass S_CHECK, results then S_CEN and S_EMIT.
// A filtered result adds S_TAP, S_TDAT, S_TACC per in-frame tap, S_TAP per skipped tap
// (9 or 25 taps, single line store port), then S_DSTART and S_DIV (bit-serial divider).
// Reset is synchronous, active low; the line store is not cleared.
// A result waiting in the output register does not block input; a new result waits for it.
`include "alpha_bilateral_filter_core_assert.svh"

module alpha_bilateral_filter_core #(
  parameter int MAX_WIDTH = abf_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic [1:0]  in_tuser,   // [0] func, [1] smooth_enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] pixel_out
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DEPTH  = 8 * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIN_W  = abf_pkg::TOTAL_W;
  localparam int XW     = COL_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_CEN, S_TAP, S_TDAT, S_TACC, S_DSTART, S_DIV, S_EMIT
  } state_t;

  state_t state_r;
  abf_pkg::cfg_t cfg;
  logic restart;

  logic [COL_W-1:0]            in_col_r, out_col_r;
  logic [abf_pkg::FH_W-1:0]    in_row_r, out_row_r;
  logic [LIN_W-1:0]            in_lin_r, out_lin_r;
  logic signed [2:0]           dx_r, dy_r;
  logic [abf_pkg::PIX_W-1:0]   center_r, pix_r, res_r;
  logic [abf_pkg::KK_W-1:0]    kk_r;
  logic [31:0]                 prod_r;
  logic [abf_pkg::SUM_W-1:0]   sum_r;
  logic [abf_pkg::TSUM_W-1:0]  tot_r;
  logic                        out_valid_r, out_last_r;
  logic [abf_pkg::PIX_W-1:0]   out_data_r;

  logic                        accept, in_open, due, ram_we;
  logic [ADDR_W-1:0]           ram_addr;
  logic [abf_pkg::CELL_W-1:0]  ram_rdata;
  logic signed [2:0]           rad_s;
  logic signed [17:0]          yy;
  logic signed [XW-1:0]        xx;
  logic                        tap_in, tap_last;
  logic [1:0]                  ax, ay;
  logic [abf_pkg::PIX_W-1:0]   diff;
  logic [abf_pkg::WGT_W-1:0]   wgt;
  logic                        div_done;
  logic [abf_pkg::NUM_W-1:0]   div_quo;
  logic                        emit_ok;

  function automatic logic [ADDR_W-1:0] slot(logic [2:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
  endfunction

  abf_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg, .restart
  );

  abf_ram #(.WIDTH(abf_pkg::CELL_W), .DEPTH(DEPTH)) u_ram (
    .clk, .we(ram_we), .addr(ram_addr), .wdata({in_tuser[1], in_tdata}), .rdata(ram_rdata)
  );

  abf_div u_div (
    .clk, .rst_n, .start(state_r == S_DSTART),
    .num(abf_pkg::NUM_W'(sum_r) + abf_pkg::NUM_W'(tot_r >> 1)),
    .den(tot_r), .done(div_done), .quo(div_quo)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_open   = in_row_r < cfg.h;
  assign ram_we    = accept && in_open && !in_tuser[0];
  assign due = (out_lin_r < cfg.total) &&
               (!in_open || ({1'b0, in_lin_r} >=
                 {1'b0, out_lin_r} + (LIN_W+1)'({cfg.w, 1'b0}) + (LIN_W+1)'(3)));

  assign rad_s    = cfg.rad1 ? 3'sd1 : 3'sd2;
  assign yy       = $signed({2'b00, out_row_r}) + 18'(dy_r);
  assign xx       = $signed({2'b00, out_col_r}) + XW'(dx_r);
  assign tap_in   = (yy >= 0) && (yy < $signed({2'b00, cfg.h})) && (xx >= 0) &&
                    (32'(xx) < 32'(cfg.w));
  assign tap_last = (dx_r == rad_s) && (dy_r == rad_s);
  assign ax       = dx_r[2] ? 2'(-dx_r) : dx_r[1:0];
  assign ay       = dy_r[2] ? 2'(-dy_r) : dy_r[1:0];
  assign diff     = (ram_rdata[7:0] > center_r) ? ram_rdata[7:0] - center_r
                                                : center_r - ram_rdata[7:0];
  assign wgt      = prod_r[30:20];
  assign emit_ok  = !out_valid_r || out_tready;

  always_comb begin
    if (state_r == S_TAP) ram_addr = slot(yy[2:0], xx[COL_W-1:0]);
    else if (state_r == S_CHECK) ram_addr = slot(out_row_r[2:0], out_col_r);
    else ram_addr = slot(in_row_r[2:0], in_col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_lin_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_lin_r   <= '0;
      out_valid_r <= 1'b0;
      dx_r        <= '0;
      dy_r        <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;
      if (restart) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_lin_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        out_lin_r <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_open && !in_tuser[0]) begin
              in_lin_r <= in_lin_r + 1'b1;
              if (32'(in_col_r) + 1 >= 32'(cfg.w)) begin
                in_col_r <= '0;
                in_row_r <= in_row_r + 1'b1;
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
              state_r <= S_CHECK;
            end else if (!in_open) begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: state_r <= due ? S_CEN : S_IDLE;
        S_CEN: begin
          center_r <= ram_rdata[7:0];
          res_r    <= ram_rdata[7:0];
          sum_r    <= '0;
          tot_r    <= '0;
          dx_r     <= -rad_s;
          dy_r     <= -rad_s;
          state_r  <= (cfg.filter_en && ram_rdata[8]) ? S_TAP : S_EMIT;
        end
        S_TAP: begin
          kk_r <= abf_pkg::KK_W'(abf_pkg::gauss(cfg.rad1, ax) * abf_pkg::gauss(cfg.rad1, ay));
          if (tap_in) begin
            state_r <= S_TDAT;
          end else if (tap_last) begin
            state_r <= S_DSTART;
          end else if (dx_r == rad_s) begin
            dx_r <= -rad_s;
            dy_r <= dy_r + 3'sd1;
          end else begin
            dx_r <= dx_r + 3'sd1;
          end
        end
        S_TDAT: begin
          pix_r   <= ram_rdata[7:0];
          prod_r  <= 32'(abf_pkg::vw_lookup(cfg.vsel, diff)) * 32'(kk_r);
          state_r <= S_TACC;
        end
        S_TACC: begin
          tot_r <= tot_r + abf_pkg::TSUM_W'(wgt);
          sum_r <= sum_r + abf_pkg::SUM_W'(19'(wgt) * 19'(pix_r));
          if (tap_last) begin
            state_r <= S_DSTART;
          end else begin
            state_r <= S_TAP;
            if (dx_r == rad_s) begin
              dx_r <= -rad_s;
              dy_r <= dy_r + 3'sd1;
            end else begin
              dx_r <= dx_r + 3'sd1;
            end
          end
        end
        S_DSTART: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_quo[7:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_last_r  <= (out_lin_r + 1'b1 == cfg.total);
            state_r     <= S_IDLE;
            if (out_lin_r + 1'b1 == cfg.total) begin
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_lin_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              out_lin_r <= '0;
            end else begin
              out_lin_r <= out_lin_r + 1'b1;
              if (32'(out_col_r) + 1 >= 32'(cfg.w)) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `ABF_ASSERT(a_div_in_div, div_done |-> state_r == S_DIV)
  `ABF_ASSERT(a_acc_after_dat, state_r == S_TACC |-> $past(state_r) == S_TDAT)
  `ABF_ASSERT(a_no_write_busy, ram_we |-> !(state_r == S_TAP || state_r == S_CHECK))
  `ABF_ASSERT(a_emit_holds, (state_r == S_EMIT && !emit_ok) |=> state_r == S_EMIT)
  `ABF_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r))

endmodule

// ===== rtl/core/abf_ram.sv =====
module abf_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/abf_cfg.sv =====
module abf_cfg #(
  parameter int MAX_WIDTH = abf_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output abf_pkg::cfg_t       cfg,
  output logic                restart
);

  logic                       filter_on_r;
  logic [abf_pkg::QF_W-1:0]   quality_r;
  logic [abf_pkg::FW_W-1:0]   width_r;
  logic [abf_pkg::FH_W-1:0]   height_r;
  logic [abf_pkg::TOTAL_W-1:0] total_r;
  logic [abf_pkg::FW_W-1:0]   eff_w;
  logic [abf_pkg::FH_W-1:0]   eff_h;
  logic                       wr;
  logic [1:0]                 idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[3:2];
  assign restart = wr && (idx == abf_pkg::REG_WIDTH || idx == abf_pkg::REG_HEIGHT);

  always_comb begin
    if (width_r == '0) eff_w = abf_pkg::FW_W'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = abf_pkg::FW_W'(MAX_WIDTH);
    else eff_w = width_r;
    eff_h = (height_r == '0) ? abf_pkg::FH_W'(1) : height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_on_r <= 1'b0;
      quality_r   <= '0;
      width_r     <= abf_pkg::FW_W'(1);
      height_r    <= abf_pkg::FH_W'(1);
      total_r     <= abf_pkg::TOTAL_W'(1);
    end else begin
      total_r <= abf_pkg::TOTAL_W'(eff_w) * abf_pkg::TOTAL_W'(eff_h);
      if (wr) begin
        case (idx)
          abf_pkg::REG_FILTER_ON: filter_on_r <= cfg_pwdata[0];
          abf_pkg::REG_QUALITY:   quality_r   <= cfg_pwdata[15:0];
          abf_pkg::REG_WIDTH:     width_r     <= cfg_pwdata[12:0];
          abf_pkg::REG_HEIGHT:    height_r    <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      abf_pkg::REG_FILTER_ON: cfg_prdata = {31'd0, filter_on_r};
      abf_pkg::REG_QUALITY:   cfg_prdata = {16'd0, quality_r};
      abf_pkg::REG_WIDTH:     cfg_prdata = {19'd0, width_r};
      abf_pkg::REG_HEIGHT:    cfg_prdata = {16'd0, height_r};
      default:                cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.filter_en = filter_on_r && (quality_r >= abf_pkg::QF_W'(abf_pkg::ENABLE_THRESHOLD));
    cfg.rad1      = quality_r < 16'd50;
    if (quality_r < 16'd20) cfg.vsel = abf_pkg::VSEL_S5;
    else if (quality_r < 16'd30) cfg.vsel = abf_pkg::VSEL_S10;
    else cfg.vsel = abf_pkg::VSEL_S20;
    cfg.w     = eff_w;
    cfg.h     = eff_h;
    cfg.total = total_r;
  end

endmodule

// ===== rtl/core/abf_div.sv =====
module abf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [abf_pkg::NUM_W-1:0]   num,
  input  logic [abf_pkg::TSUM_W-1:0]  den,
  output logic                        done,
  output logic [abf_pkg::NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(abf_pkg::NUM_W + 1);

  logic [abf_pkg::TSUM_W:0]   rem_r;
  logic [abf_pkg::NUM_W-1:0]  quo_r;
  logic [abf_pkg::TSUM_W-1:0] den_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [abf_pkg::TSUM_W+1:0] trial;

  assign trial = {rem_r, quo_r[abf_pkg::NUM_W-1]};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(abf_pkg::NUM_W);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        if (trial >= {2'b00, den_r}) begin
          rem_r <= (abf_pkg::TSUM_W+1)'(trial - {2'b00, den_r});
          quo_r <= {quo_r[abf_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[abf_pkg::TSUM_W:0];
          quo_r <= {quo_r[abf_pkg::NUM_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
